>>> rtl/core/dstq_pkg.sv
// Package for the deadline sorted timer queue.
// Holds the command codes, the transfer structs and the sequencer states.
// No dependencies.
package dstq_pkg;

    typedef enum logic [1:0] {
        CMD_ARM     = 2'd0,
        CMD_CANCEL  = 2'd1,
        CMD_POLL    = 2'd2,
        CMD_ADVANCE = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  entry_id;
        logic [31:0] delay_ticks;
    } t_in;

    typedef struct packed {
        logic       fired;
        logic [3:0] fired_id;
        logic       queue_empty;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UL_RD,
        S_UL_FIX1,
        S_UL_FIX2,
        S_POLL_RD,
        S_POLL_CMP,
        S_INS_START,
        S_INS_WALK,
        S_INS_LINK,
        S_INS_PREV,
        S_INS_NEXT,
        S_APP_NEXT,
        S_APP_PREV,
        S_RESP
    } t_state;

endpackage

>>> rtl/core/dstq_mem.sv
// Entry store of the timer queue: expiry times and next/prev links.
// Synchronous memories, one shared read address, registered read data.
// Depends on dstq_pkg.
module dstq_mem
    import dstq_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic [$clog2(ENTRIES)-1:0]  i_rd_addr,
    input  logic                        i_exp_we,
    input  logic [$clog2(ENTRIES)-1:0]  i_exp_waddr,
    input  logic [31:0]                 i_exp_wdata,
    input  logic [$clog2(ENTRIES)-1:0]  i_lnk_waddr,
    input  logic                        i_nxt_we,
    input  logic                        i_prv_we,
    input  logic [$clog2(ENTRIES)-1:0]  i_nxt_wdata,
    input  logic [$clog2(ENTRIES)-1:0]  i_prv_wdata,
    output logic [31:0]                 o_exp_rdata,
    output logic [$clog2(ENTRIES)-1:0]  o_nxt_rdata,
    output logic [$clog2(ENTRIES)-1:0]  o_prv_rdata
);

    localparam int IW = $clog2(ENTRIES);

    logic [31:0]     r_exp_mem [ENTRIES];
    logic [2*IW-1:0] r_lnk_mem [ENTRIES];
    logic [31:0]     r_exp_rd;
    logic [2*IW-1:0] r_lnk_rd;

    always_ff @(posedge i_clk) begin
        if (i_exp_we) begin
            r_exp_mem[i_exp_waddr] <= i_exp_wdata;
        end
        r_exp_rd <= r_exp_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_nxt_we) begin
            r_lnk_mem[i_lnk_waddr][2*IW-1:IW] <= i_nxt_wdata;
        end
        if (i_prv_we) begin
            r_lnk_mem[i_lnk_waddr][IW-1:0] <= i_prv_wdata;
        end
        r_lnk_rd <= r_lnk_mem[i_rd_addr];
    end

    assign o_exp_rdata = r_exp_rd;
    assign o_nxt_rdata = r_lnk_rd[2*IW-1:IW];
    assign o_prv_rdata = r_lnk_rd[IW-1:0];

endmodule

>>> rtl/core/deadline_sorted_timer_queue_top.sv
// Deadline sorted timer queue: up to ENTRIES timers in a linked list ordered by expiry,
// one command per transfer, one result strobe per command, which the receiver cannot stall.
// An arm into a non-empty queue walks the list, reading one entry per cycle through the
// single read port of the entry store. busy stays high from the accepting edge through
// the strobe cycle.
// Depends on dstq_pkg and dstq_mem.
module deadline_sorted_timer_queue_top
    import dstq_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_strobe,
    output t_out o_result
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    t_state         r_state;
    t_state         n_state;
    t_cmd           r_cmd;
    logic [IW-1:0]  r_id;
    logic [31:0]    r_xp;
    logic [31:0]    r_time;
    logic [IW-1:0]  r_head;
    logic [IW-1:0]  r_tail;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_k;
    logic [IW-1:0]  r_cur;
    logic [IW-1:0]  r_p;
    logic [IW-1:0]  r_n;
    logic [ENTRIES-1:0] r_linked;
    logic           r_fired;
    logic [3:0]     r_fired_id;

    logic           accept;
    logic           id_ok;
    logic [IW-1:0]  in_idx;

    logic [IW-1:0]  rd_addr;
    logic           exp_we;
    logic [IW-1:0]  lnk_waddr;
    logic           nxt_we;
    logic           prv_we;
    logic [IW-1:0]  nxt_wdata;
    logic [IW-1:0]  prv_wdata;
    logic [31:0]    exp_rdata;
    logic [IW-1:0]  nxt_rdata;
    logic [IW-1:0]  prv_rdata;

    logic           walk_found;
    logic           walk_last;

    assign accept     = start && (r_state == S_IDLE);
    assign in_idx     = IW'(i_in.entry_id);
    assign id_ok      = {28'd0, i_in.entry_id} < 32'(ENTRIES);
    assign walk_found = exp_rdata > r_xp;
    assign walk_last  = (r_k + CW'(1)) == r_count;

    dstq_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rd_addr   (rd_addr),
        .i_exp_we    (exp_we),
        .i_exp_waddr (r_id),
        .i_exp_wdata (r_xp),
        .i_lnk_waddr (lnk_waddr),
        .i_nxt_we    (nxt_we),
        .i_prv_we    (prv_we),
        .i_nxt_wdata (nxt_wdata),
        .i_prv_wdata (prv_wdata),
        .o_exp_rdata (exp_rdata),
        .o_nxt_rdata (nxt_rdata),
        .o_prv_rdata (prv_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in.cmd)
                        CMD_ARM: begin
                            if (!id_ok) begin
                                n_state = S_RESP;
                            end else if (r_linked[in_idx]) begin
                                n_state = S_UL_RD;
                            end else begin
                                n_state = S_INS_START;
                            end
                        end
                        CMD_CANCEL: begin
                            n_state = (id_ok && r_linked[in_idx]) ? S_UL_RD : S_RESP;
                        end
                        CMD_POLL: begin
                            n_state = (r_count != '0) ? S_POLL_RD : S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_UL_RD:    n_state = S_UL_FIX1;
            S_UL_FIX1:  n_state = S_UL_FIX2;
            S_UL_FIX2:  n_state = (r_cmd == CMD_ARM) ? S_INS_START : S_RESP;
            S_POLL_RD:  n_state = S_POLL_CMP;
            S_POLL_CMP: n_state = (exp_rdata <= r_time) ? S_UL_RD : S_RESP;
            S_INS_START: n_state = (r_count == '0) ? S_RESP : S_INS_WALK;
            S_INS_WALK: begin
                if (walk_found) begin
                    n_state = S_INS_LINK;
                end else if (walk_last) begin
                    n_state = S_APP_NEXT;
                end
            end
            S_INS_LINK: n_state = S_INS_PREV;
            S_INS_PREV: n_state = S_INS_NEXT;
            S_INS_NEXT: n_state = S_RESP;
            S_APP_NEXT: n_state = S_APP_PREV;
            S_APP_PREV: n_state = S_RESP;
            S_RESP:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        rd_addr   = r_id;
        exp_we    = 1'b0;
        lnk_waddr = r_id;
        nxt_we    = 1'b0;
        prv_we    = 1'b0;
        nxt_wdata = r_id;
        prv_wdata = r_id;
        case (r_state)
            S_POLL_RD: begin
                rd_addr = r_head;
            end
            S_UL_FIX1: begin
                lnk_waddr = prv_rdata;
                nxt_wdata = nxt_rdata;
                nxt_we    = (r_id != r_head);
            end
            S_UL_FIX2: begin
                lnk_waddr = r_n;
                prv_wdata = r_p;
                prv_we    = (r_id != r_tail);
            end
            S_INS_START: begin
                rd_addr = r_head;
                exp_we  = 1'b1;
            end
            S_INS_WALK: begin
                rd_addr = nxt_rdata;
            end
            S_INS_LINK: begin
                nxt_wdata = r_cur;
                prv_wdata = r_p;
                nxt_we    = 1'b1;
                prv_we    = 1'b1;
            end
            S_INS_PREV: begin
                lnk_waddr = r_p;
                nxt_we    = (r_cur != r_head);
            end
            S_INS_NEXT: begin
                lnk_waddr = r_cur;
                prv_we    = 1'b1;
            end
            S_APP_NEXT: begin
                lnk_waddr = r_tail;
                nxt_we    = 1'b1;
            end
            S_APP_PREV: begin
                prv_wdata = r_tail;
                prv_we    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_time   <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_linked <= '0;
            r_fired  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd      <= i_in.cmd;
                        r_id       <= in_idx;
                        r_xp       <= r_time + i_in.delay_ticks;
                        r_fired    <= 1'b0;
                        r_fired_id <= '0;
                        if (i_in.cmd == CMD_ADVANCE) begin
                            r_time <= r_time + 32'd1;
                        end
                    end
                end
                S_POLL_CMP: begin
                    if (exp_rdata <= r_time) begin
                        r_id       <= r_head;
                        r_fired    <= 1'b1;
                        r_fired_id <= 4'(r_head);
                    end
                end
                S_UL_FIX1: begin
                    r_n <= nxt_rdata;
                    r_p <= prv_rdata;
                    if (r_id == r_head) begin
                        r_head <= nxt_rdata;
                    end
                end
                S_UL_FIX2: begin
                    if (r_id == r_tail) begin
                        r_tail <= r_p;
                    end
                    r_linked[r_id] <= 1'b0;
                    r_count        <= r_count - CW'(1);
                end
                S_INS_START: begin
                    r_cur <= r_head;
                    r_k   <= '0;
                    if (r_count == '0) begin
                        r_head         <= r_id;
                        r_tail         <= r_id;
                        r_linked[r_id] <= 1'b1;
                        r_count        <= r_count + CW'(1);
                    end
                end
                S_INS_WALK: begin
                    if (walk_found) begin
                        r_p <= prv_rdata;
                    end else begin
                        r_cur <= nxt_rdata;
                        r_k   <= r_k + CW'(1);
                    end
                end
                S_INS_PREV: begin
                    if (r_cur == r_head) begin
                        r_head <= r_id;
                    end
                end
                S_INS_NEXT: begin
                    r_linked[r_id] <= 1'b1;
                    r_count        <= r_count + CW'(1);
                end
                S_APP_PREV: begin
                    r_tail         <= r_id;
                    r_linked[r_id] <= 1'b1;
                    r_count        <= r_count + CW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign busy                 = (r_state != S_IDLE);
    assign o_strobe             = (r_state == S_RESP);
    assign o_result.fired       = r_fired;
    assign o_result.fired_id    = r_fired_id;
    assign o_result.queue_empty = (r_count == '0);

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_linked) == 32'(r_count)))
        else $error("linked entries disagree with count");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_time_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> $stable(r_time))
        else $error("time moved during a command");

    a_fired_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POLL_CMP) |-> (r_count != '0))
        else $error("poll compare on empty queue");

endmodule
